// ===== design/sdta_pkg.sv =====
// ----------------------------------------------------------------------------
// sdta_pkg
// shared types and constants for the signed integer to decimal text block
// ----------------------------------------------------------------------------
package sdta_pkg;

	localparam int MAX_DIGITS    = 20;
	localparam int DIGIT_W       = 4;
	localparam int VALUE_W       = 64;
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int STEP_W        = $clog2(CONV_STEPS);

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_MINUS = 8'h2D;

	// one classified item waiting for conversion
	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               neg;
		logic [7:0]         cap;
	} sdta_item_t;

endpackage

// ===== design/sdta_in_if.sv =====
// ----------------------------------------------------------------------------
// sdta_in_if
// input channel: value and buffer capacity with valid/ready
// ----------------------------------------------------------------------------
interface sdta_in_if;

	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [7:0]         buf_size;

	modport source (output valid, output value, output buf_size, input ready);
	modport sink   (input valid, input value, input buf_size, output ready);

endinterface

// ===== design/sdta_out_if.sv =====
// ----------------------------------------------------------------------------
// sdta_out_if
// output channel: one text character per item with valid/ready
// ----------------------------------------------------------------------------
interface sdta_out_if;

	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       char_valid;
	logic [4:0] text_length;
	logic       last;

	modport source (output valid, output character, output char_valid,
		output text_length, output last, input ready);
	modport sink   (input valid, input character, input char_valid,
		input text_length, input last, output ready);

endinterface

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// signed 64-bit integer to decimal ascii text, one character per item
// ----------------------------------------------------------------------------
// each item goes through the bcd conversion (4 bits a cycle), then leaves one character
//   a cycle while out_ch.ready allows; the next item is popped only after the terminator
// the input queue keeps taking items while a conversion runs, until it is full
// reset: arst_n clears the queue, the sequencer and the output register
module signed_int_to_decimal_ascii_top import sdta_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	sdta_in_if.sink    in_ch,
	sdta_out_if.source out_ch
);

	// handoff between the classifying front end and the converter
	logic       q_valid;
	sdta_item_t q_item;
	logic       pop;

	// front end: sign split, magnitude, small queue
	sdta_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop)
	);

	// back end: bcd conversion, trimming to capacity, character stream
	sdta_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== design/sdta_front.sv =====
// ----------------------------------------------------------------------------
// sdta_front
// accepts items, splits sign from magnitude and queues them for the back end
// ----------------------------------------------------------------------------
module sdta_front import sdta_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	sdta_in_if.sink     in_ch,
	output logic        q_valid,
	output sdta_item_t  q_item,
	input  logic        pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sdta_item_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               neg;
	sdta_item_t         new_item;

	assign in_ch.ready = (cnt_q != CNT_W'(DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_item      = mem_q[rd_ptr_q];

	// magnitude fits 64 bits unsigned, also for the most negative value
	always_comb begin
		neg          = in_ch.value[VALUE_W-1];
		new_item.neg = neg;
		new_item.mag = neg ? (VALUE_W'(0) - VALUE_W'(in_ch.value)) : VALUE_W'(in_ch.value);
		new_item.cap = in_ch.buf_size;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/sdta_back.sv =====
// ----------------------------------------------------------------------------
// sdta_back
// binary to bcd conversion, length trimming and character emission
// ----------------------------------------------------------------------------
module sdta_back import sdta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  sdta_item_t  q_item,
	output logic        pop,
	sdta_out_if.source  out_ch
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_COUNT, ST_EMIT} state_t;

	state_t                              state_q;
	logic [VALUE_W-1:0]                  bin_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  bcd_q;
	logic                                neg_q;
	logic [7:0]                          cap_q;
	logic [STEP_W-1:0]                   step_q;
	logic [4:0]                          len_q;
	logic [4:0]                          rem_q;
	logic                                sign_pend_q;
	logic                                ovalid_q;
	logic [7:0]                          ochar_q;
	logic                                ocv_q;
	logic [4:0]                          olen_q;
	logic                                olast_q;

	logic [MAX_DIGITS*DIGIT_W+VALUE_W-1:0] dab;
	logic [4:0]                          ndig;
	logic [4:0]                          needed;
	logic [4:0]                          out_len;
	logic                                adv;

	// shift-and-add-3, several bits per cycle
	function automatic logic [MAX_DIGITS*DIGIT_W+VALUE_W-1:0] dabble(
		input logic [MAX_DIGITS*DIGIT_W-1:0] b,
		input logic [VALUE_W-1:0]            v
	);
		logic [MAX_DIGITS*DIGIT_W+VALUE_W-1:0] t;
		t = {b, v};
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (t[VALUE_W + d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					t[VALUE_W + d*DIGIT_W +: DIGIT_W] =
						t[VALUE_W + d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			t = t << 1;
		end
		return t;
	endfunction

	assign dab = dabble(bcd_q, bin_q);
	assign pop = (state_q == ST_IDLE) && q_valid;
	assign adv = !ovalid_q || out_ch.ready;

	// digit count, then text length clipped to the buffer
	always_comb begin
		ndig = 5'd1;
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (bcd_q[i] != '0) begin
				ndig = 5'(i + 1);
			end
		end
		needed = ndig + {4'b0, neg_q};
		if (cap_q == 8'd0) begin
			out_len = 5'd0;
		end else if ({3'b0, needed} >= cap_q) begin
			out_len = 5'(cap_q - 8'd1);
		end else begin
			out_len = needed;
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.character   = ochar_q;
	assign out_ch.char_valid  = ocv_q;
	assign out_ch.text_length = olen_q;
	assign out_ch.last        = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bin_q       <= '0;
			bcd_q       <= '0;
			neg_q       <= 1'b0;
			cap_q       <= '0;
			step_q      <= '0;
			len_q       <= '0;
			rem_q       <= '0;
			sign_pend_q <= 1'b0;
			ovalid_q    <= 1'b0;
			ochar_q     <= CHR_NUL;
			ocv_q       <= 1'b0;
			olen_q      <= '0;
			olast_q     <= 1'b0;
		end else begin
			// outside emission the output register only drains
			if (out_ch.ready && state_q != ST_EMIT) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						bin_q   <= q_item.mag;
						neg_q   <= q_item.neg;
						cap_q   <= q_item.cap;
						bcd_q   <= '0;
						step_q  <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q  <= dab[MAX_DIGITS*DIGIT_W+VALUE_W-1:VALUE_W];
					bin_q  <= dab[VALUE_W-1:0];
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CONV_STEPS - 1)) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					len_q       <= out_len;
					sign_pend_q <= neg_q && (out_len != 5'd0);
					rem_q       <= out_len - {4'b0, neg_q && (out_len != 5'd0)};
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (adv) begin
						ovalid_q <= 1'b1;
						olen_q   <= len_q;
						if (sign_pend_q) begin
							ochar_q     <= CHR_MINUS;
							ocv_q       <= 1'b1;
							olast_q     <= 1'b0;
							sign_pend_q <= 1'b0;
						end else if (rem_q != 5'd0) begin
							ochar_q <= CHR_ZERO + {4'b0, bcd_q[rem_q - 5'd1]};
							ocv_q   <= 1'b1;
							olast_q <= 1'b0;
							rem_q   <= rem_q - 5'd1;
						end else begin
							ochar_q <= CHR_NUL;
							ocv_q   <= (cap_q != 8'd0);
							olast_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rem_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> rem_q <= len_q)
		else $error("digit count exceeds text length");

	a_nocap_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !ocv_q |-> olast_q && olen_q == 5'd0)
		else $error("zero capacity result must be last with no text");

	a_conv_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |=> state_q == ST_CONV || state_q == ST_COUNT)
		else $error("conversion left early");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for signed_int_to_decimal_ascii_top: values and buffer
// capacities go in through a valid/ready driver, each accepted item is turned
// into its expected characters by a local predictor, and a monitor compares
// every character item that leaves the block against the oldest expectation
// ----------------------------------------------------------------------------
module tb import sdta_pkg::*;;

	// one conversion request waiting to be driven
	typedef struct {
		logic signed [63:0] value;
		logic [7:0]         buf_size;
		bit                 drain; // hold off until the block has gone quiet
	} conv_req_t;

	// one expected character item
	typedef struct {
		logic [7:0] character;
		logic       char_valid;
		logic [4:0] text_length;
		logic       last;
	} text_char_t;

	localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;

	sdta_in_if  in_ch ();
	sdta_out_if out_ch ();

	signed_int_to_decimal_ascii_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	conv_req_t  req_q[$];      // requests not yet presented
	text_char_t exp_chars_q[$]; // characters still owed by the block
	int         n_errors;
	int         n_taken;       // requests accepted so far
	bit         in_taken;      // the request on the bus went in at the last edge

	// ------------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		n_errors++;
	endtask

	// ------------------------------------------------------------------------
	// predictor: text that one value and capacity turn into
	// ------------------------------------------------------------------------
	function automatic void owe_char(input logic [7:0] ch, input logic v,
		input int len, input logic fin);
		text_char_t t;
		t.character   = ch;
		t.char_valid  = v;
		t.text_length = len[4:0];
		t.last        = fin;
		exp_chars_q.push_back(t);
	endfunction

	function automatic void predict_text(input logic signed [63:0] val,
		input logic [7:0] cap);
		logic [63:0] raw;
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  dig [MAX_DIGITS]; // least significant digit first
		int          ndig;
		int          capn;
		int          needed;
		int          out_len;
		int          shown;
		raw  = val;
		neg  = raw[63];
		// two's complement magnitude; the most negative value lands on 2**63
		mag  = neg ? 64'd0 - raw : raw;
		capn = int'(cap);
		// zero capacity: a single empty marker item, nothing written
		if (capn == 0) begin
			owe_char(CHR_NUL, 1'b0, 0, 1'b1);
			return;
		end
		// at least one digit, so zero gives "0"
		for (ndig = 0; ndig == 0 || (mag != 0 && ndig < MAX_DIGITS); ndig++) begin
			dig[ndig] = 4'(mag % 10);
			mag       = mag / 10;
		end
		needed  = ndig + (neg ? 1 : 0);
		out_len = (needed >= capn) ? capn - 1 : needed;
		if (out_len > 0) begin
			shown = out_len;
			// truncated negatives keep the sign and lose the top digits
			if (neg) begin
				owe_char(CHR_MINUS, 1'b1, out_len, 1'b0);
				shown = out_len - 1;
			end
			for (int i = shown; i > 0; i--)
				owe_char(CHR_ZERO + dig[i-1], 1'b1, out_len, 1'b0);
		end
		// terminator always closes the text
		owe_char(CHR_NUL, 1'b1, out_len, 1'b1);
	endfunction

	// ------------------------------------------------------------------------
	// random request content
	// ------------------------------------------------------------------------
	function automatic logic signed [63:0] pick_value();
		logic [63:0] v;
		logic [63:0] p;
		int          k;
		case ($urandom_range(0, 5))
			0, 5: v = {$urandom, $urandom};                 // whole range, every bit
			1: v = 64'($urandom_range(0, 999));             // short texts
			2: begin                                        // digit count boundaries
				p = 64'd1;
				k = $urandom_range(0, 18);
				for (int i = 0; i < k; i++)
					p = p * 10;
				v = p + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: v = {$urandom, $urandom} >> $urandom_range(0, 63); // any length
			default: begin                                  // extremes
				case ($urandom_range(0, 3))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = 64'd0;
					default: v = '1;
				endcase
			end
		endcase
		// random sign for every case but the most negative value
		if ($urandom_range(0, 1) == 1 && v != VAL_MIN)
			v = 64'd0 - v;
		return v;
	endfunction

	function automatic logic [7:0] pick_cap();
		// mostly around the interesting range, sometimes anywhere
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, 23));
		return 8'($urandom_range(0, 255));
	endfunction

	// gaps on both sides, none inside a calm window in the middle of the run
	function automatic bit take_gap();
		if (n_taken >= 150 && n_taken < 260)
			return 1'b0;
		return $urandom_range(0, 99) < 18;
	endfunction

	task automatic queue_req(input logic signed [63:0] val, input logic [7:0] cap,
		input bit drain);
		conv_req_t r;
		r.value    = val;
		r.buf_size = cap;
		r.drain    = drain;
		req_q.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// driver: inputs change on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		conv_req_t nxt;
		logic      nv;
		if (in_ch.valid && !in_taken) begin
			// not taken yet, hold the request steady
			nv = 1'b1;
		end else begin
			nv = 1'b0;
			if (arst_n && req_q.size() > 0 && !take_gap() &&
				!(req_q[0].drain && exp_chars_q.size() != 0)) begin
				nxt            = req_q.pop_front();
				in_ch.value    <= nxt.value;
				in_ch.buf_size <= nxt.buf_size;
				nv             = 1'b1;
			end
		end
		in_taken = 1'b0;
		in_ch.valid  <= nv;
		// receiver side back-pressure
		out_ch.ready <= arst_n && !take_gap();
	end

	// ------------------------------------------------------------------------
	// monitor: both channels sampled on the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		text_char_t e;
		// accepted request: work out its characters first
		if (in_ch.valid && in_ch.ready) begin
			predict_text(in_ch.value, in_ch.buf_size);
			in_taken = 1'b1;
			n_taken++;
		end
		// accepted character item: compare with the oldest expectation
		if (out_ch.valid && out_ch.ready) begin
			if (exp_chars_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected item char=%02h", out_ch.character));
			end else begin
				e = exp_chars_q.pop_front();
				if (out_ch.character !== e.character)
					flag_mismatch($sformatf("character %02h, want %02h",
						out_ch.character, e.character));
				if (out_ch.char_valid !== e.char_valid)
					flag_mismatch($sformatf("char_valid %b, want %b",
						out_ch.char_valid, e.char_valid));
				if (out_ch.text_length !== e.text_length)
					flag_mismatch($sformatf("text_length %0d, want %0d",
						out_ch.text_length, e.text_length));
				if (out_ch.last !== e.last)
					flag_mismatch($sformatf("last %b, want %b", out_ch.last, e.last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		n_errors       = 0;
		n_taken        = 0;
		in_taken       = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.value    = '0;
		in_ch.buf_size = '0;
		out_ch.ready   = 1'b0;
		arst_n         = 1'b0;

		// directed: zero, extremes, capacity corners, truncation
		queue_req(64'sd0, 8'd22, 1'b0);
		queue_req(64'sd0, 8'd1, 1'b0);          // capacity one: terminator only
		queue_req(64'sd0, 8'd2, 1'b0);
		queue_req(64'sd0, 8'd0, 1'b0);          // zero capacity
		queue_req(64'sd1, 8'd21, 1'b0);
		queue_req(-64'sd1, 8'd21, 1'b0);
		queue_req(-64'sd1, 8'd2, 1'b0);         // room for the sign only
		queue_req(-64'sd1, 8'd1, 1'b0);
		queue_req(VAL_MAX, 8'd255, 1'b0);       // large capacity
		queue_req(VAL_MAX, 8'd20, 1'b0);        // exactly fits
		queue_req(VAL_MAX, 8'd19, 1'b0);        // loses the top digit
		queue_req(VAL_MIN, 8'd21, 1'b0);        // most negative, full text
		queue_req(VAL_MIN, 8'd20, 1'b0);
		queue_req(VAL_MIN, 8'd2, 1'b0);
		queue_req(VAL_MIN, 8'd3, 1'b0);
		queue_req(VAL_MIN, 8'd0, 1'b0);
		queue_req(-64'sd123456789, 8'd5, 1'b0); // truncated negative
		queue_req(64'sd9999999999, 8'd4, 1'b0);
		queue_req(64'sd10, 8'd3, 1'b0);
		queue_req(-64'sd10, 8'd4, 1'b0);
		queue_req(-64'sd10, 8'd3, 1'b0);
		queue_req(64'sd12345, 8'd128, 1'b0);
		queue_req(VAL_MIN + 1, 8'd22, 1'b0);
		queue_req(64'sd1000000000000000000, 8'd21, 1'b0);

		// random part; a few requests wait for the block to drain first
		for (int n = 0; n < 386; n++)
			queue_req(pick_value(), pick_cap(), (n == 30 || n % 97 == 60));

		// reset held at the start, released between edges
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// everything presented, taken and answered
		while (req_q.size() != 0 || in_ch.valid || exp_chars_q.size() != 0)
			@(posedge clk);
		// room for stray items after the last expected one
		repeat (60) @(posedge clk);

		if (n_errors == 0)
			$display("signed_int_to_decimal_ascii_top test passed");
		else
			$display("signed_int_to_decimal_ascii_top test failed");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#10000000;
		$display("signed_int_to_decimal_ascii_top test failed");
		$finish;
	end

endmodule

// ===== signed_int_to_decimal_ascii_top.f =====
design/sdta_pkg.sv
design/sdta_in_if.sv
design/sdta_out_if.sv
design/sdta_front.sv
design/sdta_back.sv
design/signed_int_to_decimal_ascii_top.sv
tb/tb.sv
